// ===== rtl/lta_pkg.sv =====
// ----------------------------------------------------------------------------
// lta_pkg
// Shared types, widths and codes of the load tier admission policy unit.
// ----------------------------------------------------------------------------
package lta_pkg;

  // Tier table depth and fraction bits of each load term quotient
  localparam int TIERS     = 16;
  localparam int FRAC_BITS = 16;

  localparam int TIER_IDX_W = (TIERS > 1) ? $clog2(TIERS) : 1;

  // Fixed field widths
  localparam int IDX_FIELD_W = 4;
  localparam int TH_W        = 32;
  localparam int FLAG_W      = 3;
  localparam int CNT_W       = 24;
  localparam int WGT_W       = 16;
  localparam int TCNT_W      = 5;
  localparam int LOAD_W      = 31;
  localparam int USED_W      = 5;
  localparam int NTERMS      = 3;

  // Datapath widths
  localparam int PROD_W = WGT_W + CNT_W;
  localparam int DIVD_W = PROD_W + FRAC_BITS;
  localparam int QSUM_W = DIVD_W + 2;

  localparam logic [LOAD_W-1:0] LOAD_MAX = {LOAD_W{1'b1}};

  // Flag bits: bit0 accept_conn, bit1 accept_recv, bit2 close_old
  localparam logic [FLAG_W-1:0] FLAGS_PASS = 3'b011;

  // Queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Opcodes
  localparam logic OP_EVAL  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_GUARD_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CONN_WEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CONN_NORM      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWCONN_WEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NEWCONN_NORM   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPKT_WEIGHT   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UPPKT_NORM     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TIER_COUNT     = 3'd7;

  // Term order: connections, new connections, upstream packets
  typedef struct packed {
    logic                          guard_enable;
    logic [NTERMS-1:0][WGT_W-1:0]  weight;
    logic [NTERMS-1:0][WGT_W-1:0]  norm;
    logic [TCNT_W-1:0]             tier_count;
  } lta_cfg_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_EVAL,
    CMD_BYPASS
  } lta_kind_t;

  typedef struct packed {
    lta_kind_t                     kind;
    logic [TIER_IDX_W-1:0]         tier_idx;
    logic [TH_W-1:0]               threshold;
    logic [FLAG_W-1:0]             flags;
    logic [NTERMS-1:0][PROD_W-1:0] prod;
  } lta_cmd_t;

  typedef struct packed {
    logic [TH_W-1:0]   threshold;
    logic [FLAG_W-1:0] flags;
  } lta_tier_t;

  // Queue handshake toward the back end
  typedef struct packed {
    logic     valid;
    lta_cmd_t head;
  } lta_qhead_t;

endpackage

// ===== rtl/lta_in_if.sv =====
// ----------------------------------------------------------------------------
// lta_in_if
// Input item channel: valid/ready handshake with the item fields.
// ----------------------------------------------------------------------------
interface lta_in_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [3:0]  tier_index;
  logic signed [31:0] tier_threshold;
  logic        tier_accept_conn;
  logic        tier_accept_recv;
  logic        tier_close_old;
  logic [23:0] conn_now;
  logic [23:0] newconn_now;
  logic [23:0] uppkt_now;

  modport source (
    output valid, opcode, tier_index, tier_threshold, tier_accept_conn,
           tier_accept_recv, tier_close_old, conn_now, newconn_now, uppkt_now,
    input  ready
  );

  modport sink (
    input  valid, opcode, tier_index, tier_threshold, tier_accept_conn,
           tier_accept_recv, tier_close_old, conn_now, newconn_now, uppkt_now,
    output ready
  );
endinterface

// ===== rtl/lta_out_if.sv =====
// ----------------------------------------------------------------------------
// lta_out_if
// Result item channel: valid/ready handshake with the decision fields.
// ----------------------------------------------------------------------------
interface lta_out_if;
  logic        valid;
  logic        ready;
  logic        accept_conn;
  logic        accept_recv;
  logic        close_old;
  logic [30:0] load_value;
  logic [3:0]  tier_used;
  logic        tier_valid;

  modport source (
    output valid, accept_conn, accept_recv, close_old, load_value, tier_used,
           tier_valid,
    input  ready
  );

  modport sink (
    input  valid, accept_conn, accept_recv, close_old, load_value, tier_used,
           tier_valid,
    output ready
  );
endinterface

// ===== rtl/lta_front.sv =====
// ----------------------------------------------------------------------------
// lta_front
// Accepts items, classifies them and forms the weighted counts.
// ----------------------------------------------------------------------------
module lta_front (
  input  logic              clk,
  input  logic              rst_n,
  lta_in_if.sink            in_chan,
  input  lta_pkg::lta_cfg_t cfg,
  input  logic              q_ready,
  output logic              q_push,
  output lta_pkg::lta_cmd_t q_entry
);

  logic              stage_valid_r;
  logic              stage_valid_nxt;
  lta_pkg::lta_cmd_t cmd_r;
  lta_pkg::lta_cmd_t cmd_nxt;
  logic              take;
  logic              keep;

  assign in_chan.ready = !stage_valid_r || q_ready;
  assign take          = in_chan.valid && in_chan.ready;
  assign q_push        = stage_valid_r && q_ready;
  assign q_entry       = cmd_r;

  always_comb begin
    cmd_nxt.tier_idx  = lta_pkg::TIER_IDX_W'(in_chan.tier_index);
    cmd_nxt.threshold = in_chan.tier_threshold;
    cmd_nxt.flags     = {in_chan.tier_close_old, in_chan.tier_accept_recv,
                         in_chan.tier_accept_conn};
    cmd_nxt.prod[0]   = lta_pkg::PROD_W'(cfg.weight[0]) *
                        lta_pkg::PROD_W'(in_chan.conn_now);
    cmd_nxt.prod[1]   = lta_pkg::PROD_W'(cfg.weight[1]) *
                        lta_pkg::PROD_W'(in_chan.newconn_now);
    cmd_nxt.prod[2]   = lta_pkg::PROD_W'(cfg.weight[2]) *
                        lta_pkg::PROD_W'(in_chan.uppkt_now);
    if (in_chan.opcode == lta_pkg::OP_WRITE) begin
      cmd_nxt.kind = lta_pkg::CMD_WRITE;
    end else if (cfg.guard_enable) begin
      cmd_nxt.kind = lta_pkg::CMD_EVAL;
    end else begin
      cmd_nxt.kind = lta_pkg::CMD_BYPASS;
    end
    // drop tier writes that fall outside the table
    keep = !(in_chan.opcode == lta_pkg::OP_WRITE &&
             32'(in_chan.tier_index) >= 32'(lta_pkg::TIERS));
  end

  always_comb begin
    if (take) begin
      stage_valid_nxt = keep;
    end else if (q_push) begin
      stage_valid_nxt = 1'b0;
    end else begin
      stage_valid_nxt = stage_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_valid_r <= 1'b0;
    end else begin
      stage_valid_r <= stage_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/lta_fifo.sv =====
// ----------------------------------------------------------------------------
// lta_fifo
// Short command queue between the front end and the back end.
// ----------------------------------------------------------------------------
module lta_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  lta_pkg::lta_cmd_t   push_entry,
  output logic                push_ready,
  input  logic                pop,
  output lta_pkg::lta_qhead_t head
);

  lta_pkg::lta_cmd_t             entry_r [lta_pkg::QDEPTH];
  logic [lta_pkg::QPTR_W-1:0]    wr_ptr_r;
  logic [lta_pkg::QPTR_W-1:0]    wr_ptr_nxt;
  logic [lta_pkg::QPTR_W-1:0]    rd_ptr_r;
  logic [lta_pkg::QPTR_W-1:0]    rd_ptr_nxt;
  logic [lta_pkg::QCNT_W-1:0]    count_r;
  logic [lta_pkg::QCNT_W-1:0]    count_nxt;
  logic                          do_push;
  logic                          do_pop;

  assign push_ready = 32'(count_r) < 32'(lta_pkg::QDEPTH);
  assign do_push    = push && push_ready;
  assign do_pop     = pop && (count_r != '0);
  assign head.valid = count_r != '0;
  assign head.head  = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == lta_pkg::QDEPTH - 1) ? '0 :
                   lta_pkg::QPTR_W'(wr_ptr_r + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == lta_pkg::QDEPTH - 1) ? '0 :
                   lta_pkg::QPTR_W'(rd_ptr_r + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_nxt = lta_pkg::QCNT_W'(count_r + 1'b1);
    end else if (do_pop && !do_push) begin
      count_nxt = lta_pkg::QCNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// ===== rtl/lta_div.sv =====
// ----------------------------------------------------------------------------
// lta_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lta_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [lta_pkg::DIVD_W-1:0] dividend,
  input  logic [lta_pkg::WGT_W-1:0]  divisor,
  output logic                       done,
  output logic [lta_pkg::DIVD_W-1:0] quotient
);

  localparam int STEP_W = $clog2(lta_pkg::DIVD_W);

  logic [lta_pkg::DIVD_W-1:0] quo_r;
  logic [lta_pkg::WGT_W-1:0]  rem_r;
  logic [lta_pkg::WGT_W-1:0]  dsr_r;
  logic [STEP_W-1:0]          step_r;
  logic                       run_r;
  logic                       done_r;
  logic [lta_pkg::WGT_W:0]    rem_sh;
  logic [lta_pkg::WGT_W:0]    diff;
  logic                       ge;

  assign rem_sh   = {rem_r, quo_r[lta_pkg::DIVD_W-1]};
  assign diff     = rem_sh - {1'b0, dsr_r};
  assign ge       = rem_sh >= {1'b0, dsr_r};
  assign done     = done_r;
  assign quotient = quo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= STEP_W'(lta_pkg::DIVD_W - 1);
      end else if (run_r) begin
        step_r <= STEP_W'(step_r - 1'b1);
        if (step_r == '0) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift dividend bits out at the top, quotient bits in at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[lta_pkg::DIVD_W-2:0], ge};
      rem_r <= ge ? diff[lta_pkg::WGT_W-1:0] : rem_sh[lta_pkg::WGT_W-1:0];
    end
  end

endmodule

// ===== rtl/lta_back.sv =====
// ----------------------------------------------------------------------------
// lta_back
// Executes queued commands: tier writes, load division, tier search, bypass.
// ----------------------------------------------------------------------------
module lta_back (
  input  logic                clk,
  input  logic                rst_n,
  input  lta_pkg::lta_cfg_t   cfg,
  input  lta_pkg::lta_qhead_t q,
  output logic                q_pop,
  lta_out_if.source           out_chan
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SUM,
    ST_SRCH,
    ST_DONE
  } state_t;

  state_t                          state_r, state_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [lta_pkg::FLAG_W-1:0]      out_flags_r, out_flags_nxt;
  logic [lta_pkg::LOAD_W-1:0]      out_load_r, out_load_nxt;
  logic [lta_pkg::TIER_IDX_W-1:0]  out_sel_r, out_sel_nxt;
  logic                            out_tvalid_r, out_tvalid_nxt;
  logic [lta_pkg::FLAG_W-1:0]      res_flags_r, res_flags_nxt;
  logic [lta_pkg::TIER_IDX_W-1:0]  res_sel_r, res_sel_nxt;
  logic                            res_tvalid_r, res_tvalid_nxt;
  logic [lta_pkg::LOAD_W-1:0]      load_r, load_nxt;
  logic [lta_pkg::QSUM_W-1:0]      acc_r, acc_nxt;
  logic [lta_pkg::TIER_IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [lta_pkg::USED_W-1:0]      used_r, used_nxt;
  logic [lta_pkg::FLAG_W-1:0]      prev_flags_r, prev_flags_nxt;
  logic                            norm_bad_r, norm_bad_nxt;

  lta_pkg::lta_tier_t              mem [lta_pkg::TIERS];
  lta_pkg::lta_tier_t              rd_r;
  logic                            mem_we;
  logic [lta_pkg::TIER_IDX_W-1:0]  raddr;

  logic                            div_start;
  logic [lta_pkg::NTERMS-1:0]      div_done;
  logic [lta_pkg::DIVD_W-1:0]      div_quo [lta_pkg::NTERMS];
  logic                            norm_zero;
  logic [lta_pkg::QSUM_W-1:0]      total;
  logic                            exceed;
  logic                            last;

  for (genvar k = 0; k < lta_pkg::NTERMS; k++) begin : g_div
    lta_div u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .start    (div_start),
      .dividend ({q.head.prod[k], {lta_pkg::FRAC_BITS{1'b0}}}),
      .divisor  (cfg.norm[k]),
      .done     (div_done[k]),
      .quotient (div_quo[k])
    );
  end

  always_comb begin
    norm_zero = 1'b0;
    for (int k = 0; k < lta_pkg::NTERMS; k++) begin
      norm_zero = norm_zero || (cfg.norm[k] == '0);
    end
  end

  assign total  = acc_r + lta_pkg::QSUM_W'(div_quo[2]);
  assign exceed = $signed(rd_r.threshold) > $signed({1'b0, load_r});
  assign last   = 32'(cnt_r) == 32'(used_r) - 32'd1;

  assign out_chan.valid       = out_valid_r;
  assign out_chan.accept_conn = out_flags_r[0];
  assign out_chan.accept_recv = out_flags_r[1];
  assign out_chan.close_old   = out_flags_r[2];
  assign out_chan.load_value  = out_load_r;
  assign out_chan.tier_used   = 4'(out_sel_r);
  assign out_chan.tier_valid  = out_tvalid_r;

  always_comb begin
    state_nxt      = state_r;
    out_valid_nxt  = out_valid_r;
    out_flags_nxt  = out_flags_r;
    out_load_nxt   = out_load_r;
    out_sel_nxt    = out_sel_r;
    out_tvalid_nxt = out_tvalid_r;
    res_flags_nxt  = res_flags_r;
    res_sel_nxt    = res_sel_r;
    res_tvalid_nxt = res_tvalid_r;
    load_nxt       = load_r;
    acc_nxt        = acc_r;
    cnt_nxt        = cnt_r;
    used_nxt       = used_r;
    prev_flags_nxt = prev_flags_r;
    norm_bad_nxt   = norm_bad_r;
    q_pop          = 1'b0;
    mem_we         = 1'b0;
    div_start      = 1'b0;
    raddr          = '0;

    if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (q.valid) begin
          q_pop = 1'b1;
          case (q.head.kind)
            lta_pkg::CMD_WRITE: begin
              mem_we = 1'b1;
            end
            lta_pkg::CMD_EVAL: begin
              div_start    = 1'b1;
              norm_bad_nxt = norm_zero;
              used_nxt     = (32'(cfg.tier_count) > 32'(lta_pkg::TIERS)) ?
                             lta_pkg::USED_W'(lta_pkg::TIERS) : cfg.tier_count;
              state_nxt    = ST_DIV;
            end
            lta_pkg::CMD_BYPASS: begin
              res_flags_nxt  = lta_pkg::FLAGS_PASS;
              load_nxt       = '0;
              res_sel_nxt    = '0;
              res_tvalid_nxt = 1'b0;
              state_nxt      = ST_DONE;
            end
            default: begin
            end
          endcase
        end
      end
      ST_DIV: begin
        if (div_done[0]) begin
          acc_nxt   = lta_pkg::QSUM_W'(div_quo[0]) + lta_pkg::QSUM_W'(div_quo[1]);
          state_nxt = ST_SUM;
        end
      end
      ST_SUM: begin
        // drop fraction bits, saturate; a zero norm pins the load at max
        if (norm_bad_r ||
            (|total[lta_pkg::QSUM_W-1:lta_pkg::FRAC_BITS+lta_pkg::LOAD_W])) begin
          load_nxt = lta_pkg::LOAD_MAX;
        end else begin
          load_nxt = total[lta_pkg::FRAC_BITS+lta_pkg::LOAD_W-1:lta_pkg::FRAC_BITS];
        end
        if (used_r == '0) begin
          res_flags_nxt  = lta_pkg::FLAGS_PASS;
          res_sel_nxt    = '0;
          res_tvalid_nxt = 1'b0;
          state_nxt      = ST_DONE;
        end else begin
          cnt_nxt   = '0;
          state_nxt = ST_SRCH;
        end
      end
      ST_SRCH: begin
        raddr = lta_pkg::TIER_IDX_W'(cnt_r + 1'b1);
        if (exceed) begin
          res_flags_nxt  = (cnt_r == '0) ? rd_r.flags : prev_flags_r;
          res_sel_nxt    = (cnt_r == '0) ? '0 :
                           lta_pkg::TIER_IDX_W'(cnt_r - 1'b1);
          res_tvalid_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else if (last) begin
          res_flags_nxt  = rd_r.flags;
          res_sel_nxt    = cnt_r;
          res_tvalid_nxt = 1'b1;
          state_nxt      = ST_DONE;
        end else begin
          prev_flags_nxt = rd_r.flags;
          cnt_nxt        = lta_pkg::TIER_IDX_W'(cnt_r + 1'b1);
        end
      end
      ST_DONE: begin
        // hold the result until the output register frees up
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt  = 1'b1;
          out_flags_nxt  = res_flags_r;
          out_load_nxt   = load_r;
          out_sel_nxt    = res_sel_r;
          out_tvalid_nxt = res_tvalid_r;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_valid_r  <= out_valid_nxt;
      out_flags_r  <= out_flags_nxt;
      out_load_r   <= out_load_nxt;
      out_sel_r    <= out_sel_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      res_flags_r  <= res_flags_nxt;
      res_sel_r    <= res_sel_nxt;
      res_tvalid_r <= res_tvalid_nxt;
      load_r       <= load_nxt;
      acc_r        <= acc_nxt;
      cnt_r        <= cnt_nxt;
      used_r       <= used_nxt;
      prev_flags_r <= prev_flags_nxt;
      norm_bad_r   <= norm_bad_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q.head.tier_idx] <= '{threshold: q.head.threshold, flags: q.head.flags};
    end
    rd_r <= mem[raddr];
  end

  a_div_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(div_done) == 0 || $countones(div_done) == lta_pkg::NTERMS)
    else $error("divider lanes out of step");

  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done[0] |-> state_r == ST_DIV)
    else $error("divider finished outside the divide phase");

  a_srch_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SRCH |-> 32'(cnt_r) < 32'(used_r))
    else $error("tier search ran past the tiers in use");

  a_done_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE && out_valid_r && !out_chan.ready) |=> state_r == ST_DONE)
    else $error("result left the back end while output was stalled");

  a_default_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tvalid_r) |->
      (out_flags_r == lta_pkg::FLAGS_PASS && out_sel_r == '0))
    else $error("default decision with wrong flags");

endmodule

// ===== rtl/load_tier_admission_policy_unit.sv =====
// ----------------------------------------------------------------------------
// load_tier_admission_policy_unit
// Overload admission policy over a table of load tiers.
// ----------------------------------------------------------------------------
// A write-tier item stores one tier and gives no result; an evaluate item
// gives one decision. The front end takes one item per cycle while the
// queue has room and forms the three weighted counts; a two-entry queue
// feeds the back end. For an evaluate item with protection enabled, three
// bit-serial dividers in the back end run side by side over the 56 dividend
// bits (40 product bits plus 16 fraction bits), then the tier table is
// scanned one entry per cycle from its single read port, up to N entries,
// N being the tiers in use. Configuration writes take effect on the next
// cycle and must only be made while the unit is idle. The tier table is not
// cleared by reset; only tiers that were written may be in use.
// ----------------------------------------------------------------------------
module load_tier_admission_policy_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  lta_in_if.sink                         in_chan,
  lta_out_if.source                      out_chan,
  input  logic                           cfg_we,
  input  logic [lta_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lta_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lta_pkg::lta_cfg_t   cfg_r;
  lta_pkg::lta_cfg_t   cfg_nxt;
  logic                q_push;
  logic                q_ready;
  lta_pkg::lta_cmd_t   q_entry;
  lta_pkg::lta_qhead_t q_head;
  logic                q_pop;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        lta_pkg::CFG_GUARD_ENABLE:   cfg_nxt.guard_enable = cfg_wdata[0];
        lta_pkg::CFG_CONN_WEIGHT:    cfg_nxt.weight[0]    = cfg_wdata;
        lta_pkg::CFG_CONN_NORM:      cfg_nxt.norm[0]      = cfg_wdata;
        lta_pkg::CFG_NEWCONN_WEIGHT: cfg_nxt.weight[1]    = cfg_wdata;
        lta_pkg::CFG_NEWCONN_NORM:   cfg_nxt.norm[1]      = cfg_wdata;
        lta_pkg::CFG_UPPKT_WEIGHT:   cfg_nxt.weight[2]    = cfg_wdata;
        lta_pkg::CFG_UPPKT_NORM:     cfg_nxt.norm[2]      = cfg_wdata;
        lta_pkg::CFG_TIER_COUNT:     cfg_nxt.tier_count   = cfg_wdata[lta_pkg::TCNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lta_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .cfg     (cfg_r),
    .q_ready (q_ready),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  lta_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_entry),
    .push_ready (q_ready),
    .pop        (q_pop),
    .head       (q_head)
  );

  lta_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg_r),
    .q        (q_head),
    .q_pop    (q_pop),
    .out_chan (out_chan)
  );

endmodule

// ===== tb/tb_load_tier_admission_policy_unit.sv =====
// ----------------------------------------------------------------------------
// tb_load_tier_admission_policy_unit
// Self-checking testbench of the load tier admission policy unit. A local
// model of the tier table and of the load arithmetic predicts every decision;
// results are compared field by field in order, under random gaps on the
// input side and random stalls, including one long hold-off, on the result
// side.
// ----------------------------------------------------------------------------
module tb_load_tier_admission_policy_unit;

  localparam int  RANDOM_PHASES = 12;
  localparam int  PHASE_ITEMS   = 134;
  localparam int  SETTLE_CYCLES = 200;
  localparam int  MAX_CYCLES    = 1500000;
  localparam longint LOAD_CEIL  = 64'd2147483647;

  typedef longint unsigned u64_t;

  typedef struct {
    logic               opcode;
    logic [3:0]         tier_index;
    logic signed [31:0] tier_threshold;
    logic               tier_accept_conn;
    logic               tier_accept_recv;
    logic               tier_close_old;
    logic [23:0]        conn_now;
    logic [23:0]        newconn_now;
    logic [23:0]        uppkt_now;
  } policy_item_t;

  typedef struct {
    logic        accept_conn;
    logic        accept_recv;
    logic        close_old;
    logic [30:0] load_value;
    logic [3:0]  tier_used;
    logic        tier_valid;
  } decision_t;

  logic                           clk;
  logic                           rst_n;
  logic                           cfg_we;
  logic [lta_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [lta_pkg::CFG_DATA_W-1:0] cfg_wdata;

  lta_in_if  in_chan ();
  lta_out_if out_chan ();

  load_tier_admission_policy_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Mirror of the configuration and of the tier table
  lta_pkg::lta_cfg_t  policy;
  logic signed [31:0] tier_thresh [0:lta_pkg::TIERS-1];
  logic [2:0]         tier_flags  [0:lta_pkg::TIERS-1];

  decision_t   decisions_due [$];
  logic [30:0] recent_load;
  int          mismatch_count;
  int          cycle_count;
  int          hold_left;
  bit          tx_free;
  bit          rx_free;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // --------------------------------------------------------------------------
  // Prediction
  // --------------------------------------------------------------------------
  function automatic logic [30:0] calc_load(input logic [23:0] c, input logic [23:0] n,
                                            input logic [23:0] p);
    u64_t ip, fp, prod, w, d, cnt, total;
    logic [23:0] counts [0:2];
    bit sat;
    counts[0] = c;
    counts[1] = n;
    counts[2] = p;
    ip = 0;
    fp = 0;
    sat = 0;
    for (int k = 0; k < lta_pkg::NTERMS; k++) begin
      w = u64_t'(policy.weight[k]);
      d = u64_t'(policy.norm[k]);
      cnt = u64_t'(counts[k]);
      if (d == 0) begin
        sat = 1;
      end else begin
        prod = w * cnt;
        ip += prod / d;
        fp += ((prod % d) << lta_pkg::FRAC_BITS) / d;
      end
    end
    total = ip + (fp >> lta_pkg::FRAC_BITS);
    if (sat || total > LOAD_CEIL) total = LOAD_CEIL;
    return total[30:0];
  endfunction

  function automatic decision_t predict_decision(input policy_item_t it);
    decision_t d;
    int used;
    int i;
    int sel;
    d.accept_conn = 1'b1;
    d.accept_recv = 1'b1;
    d.close_old   = 1'b0;
    d.load_value  = '0;
    d.tier_used   = '0;
    d.tier_valid  = 1'b0;
    if (policy.guard_enable) begin
      d.load_value = calc_load(it.conn_now, it.newconn_now, it.uppkt_now);
      used = (policy.tier_count > lta_pkg::TIERS) ? lta_pkg::TIERS :
             int'(policy.tier_count);
      if (used > 0) begin
        i = 0;
        // stop at the first tier whose threshold exceeds the load
        while (i < used && !(tier_thresh[i] > $signed({1'b0, d.load_value}))) i++;
        sel = (i == 0) ? 0 : i - 1;
        d.accept_conn = tier_flags[sel][0];
        d.accept_recv = tier_flags[sel][1];
        d.close_old   = tier_flags[sel][2];
        d.tier_used   = 4'(sel);
        d.tier_valid  = 1'b1;
      end
    end
    return d;
  endfunction

  // --------------------------------------------------------------------------
  // Random values
  // --------------------------------------------------------------------------
  function automatic logic [23:0] rand_count();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 24'd0;
    if (r < 20) return 24'hFF_FFFF;
    if (r < 50) return 24'($urandom_range(0, 255));
    return 24'($urandom);
  endfunction

  function automatic logic [15:0] rand_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 16'd0;
    if (r < 20) return 16'hFFFF;
    if (r < 50) return 16'($urandom_range(1, 16));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] rand_norm();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 16'd0;
    if (r < 14) return 16'hFFFF;
    if (r < 54) return 16'($urandom_range(1, 16));
    return 16'($urandom_range(1, 65535));
  endfunction

  function automatic lta_pkg::lta_cfg_t rand_policy();
    lta_pkg::lta_cfg_t c;
    int r;
    c.guard_enable = ($urandom_range(0, 99) < 85);
    for (int k = 0; k < lta_pkg::NTERMS; k++) begin
      c.weight[k] = rand_weight();
      c.norm[k]   = rand_norm();
    end
    r = $urandom_range(0, 99);
    if (r < 15)      c.tier_count = 5'd16;
    else if (r < 20) c.tier_count = 5'd0;
    else if (r < 25) c.tier_count = 5'($urandom_range(17, 31));
    else             c.tier_count = 5'($urandom_range(1, 16));
    return c;
  endfunction

  function automatic lta_pkg::lta_cfg_t uniform_policy(input logic guard,
                                                       input logic [15:0] weight,
                                                       input logic [15:0] norm,
                                                       input logic [4:0] tiers);
    lta_pkg::lta_cfg_t c;
    c.guard_enable = guard;
    for (int k = 0; k < lta_pkg::NTERMS; k++) begin
      c.weight[k] = weight;
      c.norm[k]   = norm;
    end
    c.tier_count = tiers;
    return c;
  endfunction

  function automatic logic signed [31:0] clamp_threshold(input longint v);
    if (v > LOAD_CEIL) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  // Half the time near the loads seen lately, so that tier boundaries get hit
  function automatic logic signed [31:0] pick_threshold();
    int r;
    longint span;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom;
    if (r < 75) begin
      span = longint'(recent_load) / 4 + 8;
      return clamp_threshold(longint'(recent_load) - span +
                             longint'($urandom_range(0, 32'(2 * span))));
    end
    return $urandom_range(0, 1000);
  endfunction

  function automatic policy_item_t make_eval(input logic [23:0] c, input logic [23:0] n,
                                             input logic [23:0] p);
    policy_item_t it;
    it.opcode           = lta_pkg::OP_EVAL;
    it.tier_index       = 4'($urandom);
    it.tier_threshold   = $urandom;
    it.tier_accept_conn = 1'($urandom);
    it.tier_accept_recv = 1'($urandom);
    it.tier_close_old   = 1'($urandom);
    it.conn_now         = c;
    it.newconn_now      = n;
    it.uppkt_now        = p;
    return it;
  endfunction

  function automatic policy_item_t make_write(input logic [3:0] idx,
                                              input logic signed [31:0] thr,
                                              input logic [2:0] flags);
    policy_item_t it;
    it.opcode           = lta_pkg::OP_WRITE;
    it.tier_index       = idx;
    it.tier_threshold   = thr;
    it.tier_accept_conn = flags[0];
    it.tier_accept_recv = flags[1];
    it.tier_close_old   = flags[2];
    it.conn_now         = 24'($urandom);
    it.newconn_now      = 24'($urandom);
    it.uppkt_now        = 24'($urandom);
    return it;
  endfunction

  function automatic int tx_gap();
    int r;
    if (tx_free) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic send_item(input policy_item_t it);
    int gap;
    gap = tx_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid            <= 1'b1;
    in_chan.opcode           <= it.opcode;
    in_chan.tier_index       <= it.tier_index;
    in_chan.tier_threshold   <= it.tier_threshold;
    in_chan.tier_accept_conn <= it.tier_accept_conn;
    in_chan.tier_accept_recv <= it.tier_accept_recv;
    in_chan.tier_close_old   <= it.tier_close_old;
    in_chan.conn_now         <= it.conn_now;
    in_chan.newconn_now      <= it.newconn_now;
    in_chan.uppkt_now        <= it.uppkt_now;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    // item accepted at this edge
    if (it.opcode == lta_pkg::OP_WRITE) begin
      tier_thresh[it.tier_index] = it.tier_threshold;
      tier_flags[it.tier_index]  = {it.tier_close_old, it.tier_accept_recv,
                                    it.tier_accept_conn};
    end else begin
      decisions_due.push_back(predict_decision(it));
      if (policy.guard_enable) recent_load = decisions_due[$].load_value;
    end
  endtask

  task automatic write_reg(input logic [lta_pkg::CFG_IDX_W-1:0] idx,
                           input logic [lta_pkg::CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
  endtask

  task automatic apply_config(input lta_pkg::lta_cfg_t c);
    write_reg(lta_pkg::CFG_GUARD_ENABLE,   16'(c.guard_enable));
    write_reg(lta_pkg::CFG_CONN_WEIGHT,    c.weight[0]);
    write_reg(lta_pkg::CFG_CONN_NORM,      c.norm[0]);
    write_reg(lta_pkg::CFG_NEWCONN_WEIGHT, c.weight[1]);
    write_reg(lta_pkg::CFG_NEWCONN_NORM,   c.norm[1]);
    write_reg(lta_pkg::CFG_UPPKT_WEIGHT,   c.weight[2]);
    write_reg(lta_pkg::CFG_UPPKT_NORM,     c.norm[2]);
    write_reg(lta_pkg::CFG_TIER_COUNT,     16'(c.tier_count));
    cfg_we <= 1'b0;
    policy = c;
  endtask

  // Drop valid, wait for every decision, then let trailing tier writes finish
  task automatic settle();
    in_chan.valid <= 1'b0;
    while (decisions_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Result side
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int  run_left;
    bit  level;
    run_left = 0;
    level = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        level = 1'b0;
        run_left = 0;
      end else if (rx_free) begin
        level = 1'b1;
      end else if (run_left == 0) begin
        level = ($urandom_range(0, 99) < 70);
        run_left = ($urandom_range(0, 99) < 90) ? $urandom_range(1, 3) : $urandom_range(10, 50);
      end else begin
        run_left--;
      end
      out_chan.ready <= level;
    end
  end

  task automatic report_mismatch(input string field, input u64_t got, input u64_t want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", field, got, want, cycle_count);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : check_results
    decision_t want;
    if (rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (decisions_due.size() == 0) begin
        report_mismatch("result with no decision due", 1, 0);
      end else begin
        want = decisions_due.pop_front();
        if (out_chan.accept_conn !== want.accept_conn)
          report_mismatch("accept_conn", u64_t'(out_chan.accept_conn),
                          u64_t'(want.accept_conn));
        if (out_chan.accept_recv !== want.accept_recv)
          report_mismatch("accept_recv", u64_t'(out_chan.accept_recv),
                          u64_t'(want.accept_recv));
        if (out_chan.close_old !== want.close_old)
          report_mismatch("close_old", u64_t'(out_chan.close_old),
                          u64_t'(want.close_old));
        if (out_chan.load_value !== want.load_value)
          report_mismatch("load_value", u64_t'(out_chan.load_value),
                          u64_t'(want.load_value));
        if (out_chan.tier_used !== want.tier_used)
          report_mismatch("tier_used", u64_t'(out_chan.tier_used),
                          u64_t'(want.tier_used));
        if (out_chan.tier_valid !== want.tier_valid)
          report_mismatch("tier_valid", u64_t'(out_chan.tier_valid),
                          u64_t'(want.tier_valid));
      end
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < MAX_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  task automatic test_guard_off();
    apply_config(uniform_policy(1'b0, 16'hFFFF, 16'd1, 5'd16));
    send_item(make_eval(24'd0, 24'd0, 24'd0));
    send_item(make_eval(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
    settle();
  endtask

  // Ascending table from the lowest to the highest threshold, all flag patterns
  task automatic test_tier_fill();
    logic signed [31:0] thr;
    for (int i = 0; i < lta_pkg::TIERS; i++) begin
      if (i == 0)                       thr = 32'h8000_0000;
      else if (i == lta_pkg::TIERS - 1) thr = 32'h7FFF_FFFF;
      else if (i == 1)                  thr = 32'sd0;
      else                              thr = 32'(10 * i);
      send_item(make_write(4'(i), thr, 3'(i)));
    end
    settle();
  endtask

  task automatic test_no_tiers();
    apply_config(uniform_policy(1'b1, 16'd1, 16'd1, 5'd0));
    send_item(make_eval(24'd5, 24'd6, 24'd7));
    settle();
  endtask

  // With unit weights and norms the load is the plain sum of the counts
  task automatic test_tier_search();
    apply_config(uniform_policy(1'b1, 16'd1, 16'd1, 5'd16));
    send_item(make_eval(24'd0, 24'd0, 24'd0));
    send_item(make_eval(24'd20, 24'd0, 24'd0));
    send_item(make_eval(24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF));
    // first tier already above the load
    send_item(make_write(4'd0, 32'sd1000, 3'b101));
    send_item(make_eval(24'd2, 24'd2, 24'd1));
    send_item(make_write(4'd0, 32'h8000_0000, 3'b000));
    settle();
  endtask

  task automatic test_saturation_and_rounding();
    lta_pkg::lta_cfg_t c;
    c = uniform_policy(1'b1, 16'd1, 16'd3, 5'd16);
    c.norm[0] = 16'd0;
    apply_config(c);
    send_item(make_eval(24'd1, 24'd1, 24'd1));
    settle();
    // fractions of thirds add up to a carry only once they exceed one
    apply_config(uniform_policy(1'b1, 16'd1, 16'd3, 5'd16));
    send_item(make_eval(24'd1, 24'd1, 24'd1));
    send_item(make_eval(24'd2, 24'd2, 24'd2));
    settle();
  endtask

  task automatic test_backpressure();
    lta_pkg::lta_cfg_t c;
    c = rand_policy();
    c.guard_enable = 1'b1;
    c.tier_count = 5'd16;
    apply_config(c);
    tx_free = 1'b1;
    hold_left = 600;
    repeat (20) send_item(make_eval(rand_count(), rand_count(), rand_count()));
    tx_free = 1'b0;
    settle();
  endtask

  task automatic test_random();
    lta_pkg::lta_cfg_t c;
    logic [30:0]       scale;
    longint            step;
    longint            acc;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0:       c = uniform_policy(1'b1, 16'hFFFF, 16'd1, 5'd16);
        1:       c = uniform_policy(1'b1, 16'd1, 16'hFFFF, 5'd31);
        2:       c = uniform_policy(1'b1, 16'hFFFF, 16'hFFFF, 5'd16);
        default: c = rand_policy();
      endcase
      tx_free = (phase % 5 == 4);
      rx_free = tx_free;
      apply_config(c);
      // ramp the table over the load range this setting produces
      scale = calc_load(rand_count(), rand_count(), rand_count());
      step = longint'(scale) / 8 + 1;
      acc = -longint'($urandom_range(0, 8));
      for (int i = 0; i < lta_pkg::TIERS; i++) begin
        send_item(make_write(4'(i), clamp_threshold(acc), 3'($urandom)));
        acc += longint'($urandom_range(0, 32'(2 * step)));
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 99) < 80)
          send_item(make_eval(rand_count(), rand_count(), rand_count()));
        else
          send_item(make_write(4'($urandom), pick_threshold(), 3'($urandom)));
      end
      settle();
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  initial begin
    mismatch_count = 0;
    hold_left      = 0;
    tx_free        = 1'b0;
    rx_free        = 1'b0;
    recent_load    = '0;
    policy         = uniform_policy(1'b0, 16'd0, 16'd0, 5'd0);
    rst_n                    <= 1'b0;
    cfg_we                   <= 1'b0;
    cfg_index                <= '0;
    cfg_wdata                <= '0;
    in_chan.valid            <= 1'b0;
    in_chan.opcode           <= lta_pkg::OP_EVAL;
    in_chan.tier_index       <= '0;
    in_chan.tier_threshold   <= '0;
    in_chan.tier_accept_conn <= 1'b0;
    in_chan.tier_accept_recv <= 1'b0;
    in_chan.tier_close_old   <= 1'b0;
    in_chan.conn_now         <= '0;
    in_chan.newconn_now      <= '0;
    in_chan.uppkt_now        <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    test_guard_off();
    test_tier_fill();
    test_no_tiers();
    test_tier_search();
    test_saturation_and_rounding();
    test_backpressure();
    test_random();

    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== load_tier_admission_policy_unit.f =====
rtl/lta_pkg.sv
rtl/lta_in_if.sv
rtl/lta_out_if.sv
rtl/lta_front.sv
rtl/lta_fifo.sv
rtl/lta_div.sv
rtl/lta_back.sv
rtl/load_tier_admission_policy_unit.sv
tb/tb_load_tier_admission_policy_unit.sv
